@@ rtl/assert_macros.svh @@
// Assertion macros used by the port checker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication with asynchronous reset disable.
`define CHT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Signal must not be unknown while enabled.
`define CHT_ASSERT_KNOWN(label, clk, rst_n, en, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) en |-> !$isunknown(sig)) \
    else $error(msg);
`endif

@@ rtl/cht_pkg.sv @@
// Shared types and constants for the chained hash table.
// Depends on nothing.
package cht_pkg;
  localparam int unsigned MaxBucketsDef  = 64;
  localparam int unsigned PoolEntriesDef = 256;
  // Key code reaches 260*31 + 10*31 + 15 = 8385 for out-of-range symbols.
  localparam int unsigned CodeW          = 14;
  localparam int unsigned NumW           = 32;
  localparam int unsigned PayW           = 64;
  localparam int unsigned SizeW          = 7;
  localparam int unsigned BucketW        = 6;
  localparam logic [SizeW-1:0] SizeRst   = 7'd31;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_SEARCH = 1'b1
  } req_e;

  // Classified request from front to back.
  typedef struct packed {
    logic             search;
    logic [CodeW-1:0] code;
    logic [15:0]      bkt;
    logic [NumW-1:0]  num;
    logic [PayW-1:0]  pay;
  } req_t;
endpackage

@@ rtl/cht_ram.sv @@
// Generic single-port-write, one-read RAM with registered read.
// Depends on nothing.
module cht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/cht_front.sv @@
// Front end: linear key code and bucket by iterative restoring modulo.
// Depends on cht_pkg.
module cht_front #(
  parameter int unsigned MaxBuckets = cht_pkg::MaxBucketsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [cht_pkg::SizeW-1:0] table_size_i,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic                      req_type_i,
  input  logic [4:0]                first_letter_i,
  input  logic [4:0]                second_letter_i,
  input  logic [3:0]                key_digit_i,
  input  logic [cht_pkg::NumW-1:0]  entry_number_i,
  input  logic [cht_pkg::PayW-1:0]  entry_payload_i,
  output logic                      q_valid_o,
  input  logic                      q_ready_i,
  output cht_pkg::req_t             q_data_o
);
  localparam int unsigned CodeW = cht_pkg::CodeW;
  localparam int unsigned StepW = $clog2(CodeW + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_e;

  state_e              state_q;
  logic [StepW-1:0]    step_q;
  logic [CodeW-1:0]    quo_q;
  logic [15:0]         rem_q, div_q;
  cht_pkg::req_t       req_q;
  logic [CodeW-1:0]    code_w;
  logic [15:0]         div_w, trial;

  assign code_w = CodeW'(13'd260 * first_letter_i) + CodeW'(13'd10 * second_letter_i)
                + CodeW'(key_digit_i);
  // Clamp size into 1..MaxBuckets.
  always_comb begin
    if (table_size_i == '0) begin
      div_w = 16'd1;
    end else if (32'(table_size_i) > MaxBuckets) begin
      div_w = 16'(MaxBuckets);
    end else begin
      div_w = 16'(table_size_i);
    end
  end
  assign trial = {rem_q[14:0], quo_q[CodeW-1]};

  assign full_o    = (state_q != S_IDLE);
  assign q_valid_o = (state_q == S_OUT);
  assign q_data_o  = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (push_i) begin
          state_q <= S_DIV;
          step_q  <= '0;
        end
        S_DIV: begin
          step_q <= step_q + 1'b1;
          if (32'(step_q) == CodeW - 1) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: if (q_ready_i) begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload datapath: one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && push_i) begin
      req_q.search <= req_type_i;
      req_q.code   <= code_w;
      req_q.num    <= entry_number_i;
      req_q.pay    <= entry_payload_i;
      quo_q        <= code_w;
      rem_q        <= '0;
      div_q        <= div_w;
    end else if (state_q == S_DIV) begin
      quo_q <= {quo_q[CodeW-2:0], 1'b0};
      if (trial >= div_q) begin
        rem_q <= trial - div_q;
      end else begin
        rem_q <= trial;
      end
      if (32'(step_q) == CodeW - 1) begin
        req_q.bkt <= (trial >= div_q) ? trial - div_q : trial;
      end
    end
  end
endmodule

@@ rtl/cht_back.sv @@
// Back end: chain walk over the entry pool, insert at head, result register.
// Depends on cht_pkg and cht_ram.
module cht_back #(
  parameter int unsigned MaxBuckets  = cht_pkg::MaxBucketsDef,
  parameter int unsigned PoolEntries = cht_pkg::PoolEntriesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  cht_pkg::req_t               q_data_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [2:0]                  status_o,
  output logic [cht_pkg::BucketW-1:0] bucket_o,
  output logic [cht_pkg::NumW-1:0]    found_number_o,
  output logic [cht_pkg::PayW-1:0]    found_payload_o
);
  localparam int unsigned BW = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int unsigned SW = (PoolEntries > 1) ? $clog2(PoolEntries) : 1;
  localparam int unsigned UW = $clog2(PoolEntries + 1);
  localparam int unsigned NW = SW + 1; // link plus valid
  localparam int unsigned EW = cht_pkg::CodeW + NW;

  typedef enum logic [2:0] {S_IDLE, S_HEAD, S_RD, S_CMP, S_DATA, S_DONE} state_e;

  state_e            state_q;
  cht_pkg::req_t     req_q;
  logic [MaxBuckets-1:0] hvalid_q;
  logic [UW-1:0]     used_q, steps_q;
  logic [SW-1:0]     cur_q;
  logic              res_valid_q;
  logic [2:0]        status_q;
  logic [cht_pkg::NumW-1:0] fnum_q;
  logic [cht_pkg::PayW-1:0] fpay_q;

  logic              ins_w;
  logic [SW-1:0]     head_rd, head_wd;
  logic [BW-1:0]     bidx, head_ra;
  logic [EW-1:0]     ent_rd, ent_wd;
  logic [cht_pkg::NumW+cht_pkg::PayW-1:0] dat_rd;
  logic [SW-1:0]     ent_ra, new_slot;
  logic              nxt_valid;
  logic [SW-1:0]     nxt_slot;

  assign bidx     = BW'(req_q.bkt);
  assign new_slot = SW'(used_q);
  assign head_wd  = new_slot;
  // Entry word: key, next valid, next link.
  assign ent_wd   = {req_q.code, hvalid_q[bidx], head_rd};
  assign nxt_valid = ent_rd[SW];
  assign nxt_slot  = ent_rd[SW-1:0];

  // Decide at head or compare: insert when chain exhausted and pool has room.
  logic hit, walk_end;
  assign hit      = (state_q == S_CMP) && (ent_rd[EW-1 -: cht_pkg::CodeW] == req_q.code);
  assign walk_end = !nxt_valid || (steps_q + 1'b1 >= used_q);
  logic ins_now;
  assign ins_now  = !req_q.search && (used_q < UW'(PoolEntries));
  // Hold the entry read on the current slot; the head read seeds the walk.
  assign ent_ra   = (state_q == S_HEAD) ? head_rd : cur_q;
  // Read the incoming bucket on accept, then hold the accepted bucket.
  assign head_ra  = (state_q == S_IDLE) ? BW'(q_data_i.bkt) : bidx;

  assign ins_w = (state_q == S_DONE) && (status_q == cht_pkg::ST_INSERTED) && !res_valid_q;

  cht_ram #(.Width(SW), .Depth(MaxBuckets)) u_head (
    .clk_i, .we_i(ins_w), .waddr_i(bidx), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd));
  cht_ram #(.Width(EW), .Depth(PoolEntries)) u_ent (
    .clk_i, .we_i(ins_w), .waddr_i(new_slot), .wdata_i(ent_wd),
    .raddr_i(ent_ra), .rdata_o(ent_rd));
  cht_ram #(.Width(cht_pkg::NumW + cht_pkg::PayW), .Depth(PoolEntries)) u_dat (
    .clk_i, .we_i(ins_w), .waddr_i(new_slot), .wdata_i({req_q.num, req_q.pay}),
    .raddr_i(cur_q), .rdata_o(dat_rd));

  assign q_ready_o       = (state_q == S_IDLE) && !res_valid_q;
  assign empty_o         = !res_valid_q;
  assign status_o        = status_q;
  assign bucket_o        = cht_pkg::BucketW'(req_q.bkt);
  assign found_number_o  = fnum_q;
  assign found_payload_o = fpay_q;

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) begin
      req_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hvalid_q    <= '0;
      used_q      <= '0;
      steps_q     <= '0;
      cur_q       <= '0;
      res_valid_q <= 1'b0;
      status_q    <= cht_pkg::ST_INSERTED;
      fnum_q      <= '0;
      fpay_q      <= '0;
    end else begin
      if (res_valid_q && pop_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (q_valid_i && q_ready_o) begin
          state_q <= S_HEAD; // head RAM read issued on accept
        end
        S_HEAD: begin
          steps_q <= '0;
          cur_q   <= head_rd;
          if (hvalid_q[bidx] && used_q != '0) begin
            state_q <= S_CMP; // entry read of head_rd issued this cycle
          end else begin
            state_q  <= S_DONE;
            status_q <= req_q.search ? cht_pkg::ST_NOT_FOUND
                      : (ins_now ? cht_pkg::ST_INSERTED : cht_pkg::ST_FULL);
          end
        end
        S_CMP: begin
          if (hit) begin
            state_q <= S_DATA;
          end else if (walk_end) begin
            state_q  <= S_DONE;
            status_q <= req_q.search ? cht_pkg::ST_NOT_FOUND
                      : (ins_now ? cht_pkg::ST_INSERTED : cht_pkg::ST_FULL);
          end else begin
            steps_q <= steps_q + 1'b1;
            cur_q   <= nxt_slot;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_CMP;
        S_DATA: begin
          state_q  <= S_DONE;
          status_q <= req_q.search ? cht_pkg::ST_FOUND : cht_pkg::ST_DUPLICATE;
        end
        S_DONE: begin
          res_valid_q <= 1'b1;
          state_q     <= S_IDLE;
          fnum_q      <= (status_q == cht_pkg::ST_FOUND)
                       ? dat_rd[cht_pkg::PayW +: cht_pkg::NumW] : '0;
          fpay_q      <= (status_q == cht_pkg::ST_FOUND) ? dat_rd[cht_pkg::PayW-1:0] : '0;
          if (ins_w) begin
            hvalid_q[bidx] <= 1'b1;
            used_q         <= used_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/chained_hash_table_insert_search.sv @@
// Top level of the separate-chaining hash table (insert and search).
// Depends on cht_pkg, cht_front, cht_back and cht_ram.
//
// Queue-like on both sides: push a request word while full is low, pop the
// result word while empty is low. The front computes the 14-bit key code and
// the bucket with a bit-per-cycle restoring modulo, then holds the word in
// S_OUT until the back takes it and accepts no new word before then.
// The back reads the bucket head, then walks the chain with one entry RAM
// read per entry, and writes inserts at the chain head.
// From acceptance the back passes through S_HEAD, then S_CMP and S_RD per
// entry walked, S_DATA on a hit and S_DONE, which loads the result word.
// The back takes its next word only after the result is popped; short
// chains leave the division setting the rate, long chains the walk. Bucket
// heads carry valid flip-flops cleared by reset, so no clearing pass is
// needed. table_size is clamped to 1..MaxBuckets and must only be written
// while idle.
module chained_hash_table_insert_search #(
  parameter int unsigned MaxBuckets  = cht_pkg::MaxBucketsDef,
  parameter int unsigned PoolEntries = cht_pkg::PoolEntriesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cht_pkg::SizeW-1:0]   cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic                        req_type_i,
  input  logic [4:0]                  first_letter_i,
  input  logic [4:0]                  second_letter_i,
  input  logic [3:0]                  key_digit_i,
  input  logic [cht_pkg::NumW-1:0]    entry_number_i,
  input  logic [cht_pkg::PayW-1:0]    entry_payload_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [2:0]                  status_o,
  output logic [cht_pkg::BucketW-1:0] bucket_o,
  output logic [cht_pkg::NumW-1:0]    found_number_o,
  output logic [cht_pkg::PayW-1:0]    found_payload_o
);
  logic [cht_pkg::SizeW-1:0] size_q;
  logic                      q_valid, q_ready;
  cht_pkg::req_t             q_data;

  // Hold the table size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= cht_pkg::SizeRst;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  cht_front #(.MaxBuckets(MaxBuckets)) u_front (
    .clk_i, .rst_ni, .table_size_i(size_q), .push_i(push), .full_o(full),
    .req_type_i, .first_letter_i, .second_letter_i, .key_digit_i,
    .entry_number_i, .entry_payload_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data));

  cht_back #(.MaxBuckets(MaxBuckets), .PoolEntries(PoolEntries)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .empty_o(empty), .pop_i(pop), .status_o, .bucket_o,
    .found_number_o, .found_payload_o);
endmodule

@@ rtl/cht_checker.sv @@
// Port-level checker for the hash table, bound to the top level.
// Depends on assert_macros.svh and cht_pkg.
`include "assert_macros.svh"
module cht_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  status_o,
  input logic [31:0] found_number_o,
  input logic [63:0] found_payload_o
);
  logic found;
  logic [2:0] st_max;
  assign found  = (status_o == cht_pkg::ST_FOUND);
  assign st_max = cht_pkg::ST_FULL;

  `CHT_ASSERT(a_status_range, clk_i, rst_ni, !empty |-> status_o <= st_max, "bad status")
  `CHT_ASSERT(a_zero_num, clk_i, rst_ni, (!empty && !found) |-> found_number_o == '0, "num set")
  `CHT_ASSERT(a_zero_pay, clk_i, rst_ni, (!empty && !found) |-> found_payload_o == '0, "pay set")
  `CHT_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(status_o)), "dropped")
endmodule

bind chained_hash_table_insert_search cht_port_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .status_o, .found_number_o, .found_payload_o);

@@ sim/cht_checker.sv @@
// Checker for the chained hash table: mirrors the table, predicts every result word.
// Depends on cht_pkg; watches the request, result and table_size write ports.
module cht_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cht_pkg::SizeW-1:0]   cfg_wdata_i,
  input  logic                        push,
  input  logic                        full,
  input  logic                        req_type_i,
  input  logic [4:0]                  first_letter_i,
  input  logic [4:0]                  second_letter_i,
  input  logic [3:0]                  key_digit_i,
  input  logic [cht_pkg::NumW-1:0]    entry_number_i,
  input  logic [cht_pkg::PayW-1:0]    entry_payload_i,
  input  logic                        empty,
  input  logic                        pop,
  input  logic [2:0]                  status_o,
  input  logic [cht_pkg::BucketW-1:0] bucket_o,
  input  logic [cht_pkg::NumW-1:0]    found_number_o,
  input  logic [cht_pkg::PayW-1:0]    found_payload_o,
  output int                          errors_o,
  output int                          pending_o,
  output int                          checked_o,
  output int                          found_hits_o,
  output int                          full_hits_o
);
  import cht_pkg::*;

  localparam int Buckets = MaxBucketsDef;
  localparam int Pool    = PoolEntriesDef;

  typedef struct {
    status_e              status;
    logic [BucketW-1:0]   bucket;
    logic [NumW-1:0]      number;
    logic [PayW-1:0]      payload;
  } answer_t;

  // Mirror of the table contents.
  logic             head_ok   [Buckets];
  int               head_slot [Buckets];
  logic [15:0]      key_of    [Pool];
  logic [NumW-1:0]  number_of [Pool];
  logic [PayW-1:0]  payload_of[Pool];
  int               next_slot [Pool];
  logic             next_ok   [Pool];
  int               slots_taken;
  logic [SizeW-1:0] size_reg;

  answer_t answers_due[$];

  task automatic lookup_request(input logic srch, input logic [4:0] f, input logic [4:0] s,
                                input logic [3:0] d, input logic [NumW-1:0] num,
                                input logic [PayW-1:0] pay);
    int      lin, div, b, cur, steps, hit;
    logic    ok, found;
    answer_t a;
    lin = 260 * f + 10 * s + d;
    div = (size_reg == 0) ? 1 : (size_reg > Buckets) ? Buckets : size_reg;
    b = lin % div;
    ok = head_ok[b];
    cur = head_slot[b];
    steps = 0;
    found = 1'b0;
    hit = 0;
    // Follow valid links only, never more than the slots in use.
    while (ok && steps < slots_taken && !found && cur < Pool) begin
      if (key_of[cur] == lin[15:0]) begin
        found = 1'b1;
        hit = cur;
      end else begin
        ok = next_ok[cur];
        cur = next_slot[cur];
        steps++;
      end
    end
    a.bucket = b[BucketW-1:0];
    a.number = '0;
    a.payload = '0;
    if (srch == REQ_INSERT) begin
      if (found) a.status = ST_DUPLICATE;
      else if (slots_taken >= Pool) a.status = ST_FULL;
      else begin
        key_of[slots_taken] = lin[15:0];
        number_of[slots_taken] = num;
        payload_of[slots_taken] = pay;
        next_slot[slots_taken] = head_slot[b];
        next_ok[slots_taken] = head_ok[b];
        head_slot[b] = slots_taken;
        head_ok[b] = 1'b1;
        slots_taken++;
        a.status = ST_INSERTED;
      end
    end else if (found) begin
      a.status = ST_FOUND;
      a.number = number_of[hit];
      a.payload = payload_of[hit];
    end else begin
      a.status = ST_NOT_FOUND;
    end
    answers_due = {answers_due, a};
  endtask

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t a;
    if (!rst_ni) begin
      for (int i = 0; i < Buckets; i++) begin
        head_ok[i] = 1'b0;
        head_slot[i] = 0;
      end
      slots_taken = 0;
      size_reg = SizeRst;
      answers_due.delete();
      errors_o = 0;
      checked_o = 0;
      found_hits_o = 0;
      full_hits_o = 0;
    end else begin
      // Check the result word before the request of the same edge updates the mirror.
      if (pop && !empty) begin
        if (answers_due.size() == 0) begin
          report($sformatf("result word with nothing expected, status %0d", status_o));
        end else begin
          a = answers_due.pop_front();
          checked_o++;
          if (a.status == ST_FOUND) found_hits_o++;
          if (a.status == ST_FULL) full_hits_o++;
          if (status_o !== a.status)
            report($sformatf("status %0d, expected %0d", status_o, a.status));
          if (bucket_o !== a.bucket)
            report($sformatf("bucket %0d, expected %0d", bucket_o, a.bucket));
          if (found_number_o !== a.number)
            report($sformatf("number %h, expected %h", found_number_o, a.number));
          if (found_payload_o !== a.payload)
            report($sformatf("payload %h, expected %h", found_payload_o, a.payload));
        end
      end
      // A request taken on the same edge as a size write still sees the old size.
      if (push && !full)
        lookup_request(req_type_i, first_letter_i, second_letter_i, key_digit_i,
                       entry_number_i, entry_payload_i);
      if (cfg_we_i) size_reg = cfg_wdata_i;
    end
    pending_o = answers_due.size();
  end
endmodule

@@ sim/tb_chained_hash_table_insert_search.sv @@
// Testbench top for the chained hash table: clock, reset, request and result stimulus.
// Depends on cht_pkg, cht_checker and the chained_hash_table_insert_search RTL.
module tb_chained_hash_table_insert_search;
  import cht_pkg::*;

  localparam int StallLimit = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [SizeW-1:0]    cfg_wdata_i = '0;
  logic                push = 1'b0;
  logic                full;
  logic                req_type_i = 1'b0;
  logic [4:0]          first_letter_i = '0;
  logic [4:0]          second_letter_i = '0;
  logic [3:0]          key_digit_i = '0;
  logic [NumW-1:0]     entry_number_i = '0;
  logic [PayW-1:0]     entry_payload_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [2:0]          status_o;
  logic [BucketW-1:0]  bucket_o;
  logic [NumW-1:0]     found_number_o;
  logic [PayW-1:0]     found_payload_o;

  int  errors, pending, checked, found_hits, full_hits;
  bit  steady;          // set: neither side idles
  int  idle_cycles;
  logic [13:0] keys_used[$];   // {first, second, digit} of inserted keys

  chained_hash_table_insert_search u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .push, .full,
    .req_type_i, .first_letter_i, .second_letter_i, .key_digit_i,
    .entry_number_i, .entry_payload_i, .empty, .pop,
    .status_o, .bucket_o, .found_number_o, .found_payload_o
  );

  cht_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .push, .full,
    .req_type_i, .first_letter_i, .second_letter_i, .key_digit_i,
    .entry_number_i, .entry_payload_i, .empty, .pop,
    .status_o, .bucket_o, .found_number_o, .found_payload_o,
    .errors_o(errors), .pending_o(pending), .checked_o(checked),
    .found_hits_o(found_hits), .full_hits_o(full_hits)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Randomly hold off pop, except during the steady stretch.
  always @(negedge clk_i) begin
    pop <= steady ? 1'b1 : ($urandom_range(99) >= 37);
  end

  // Watchdog: count cycles with no word moved on either side.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one request word and hold it until the block takes it.
  task automatic send_word(input logic srch, input logic [4:0] f, input logic [4:0] s,
                           input logic [3:0] d, input logic [NumW-1:0] num,
                           input logic [PayW-1:0] pay);
    if (!steady) begin
      while ($urandom_range(99) < 37) begin
        push = 1'b0;
        @(negedge clk_i);
      end
    end
    push = 1'b1;
    req_type_i = srch;
    first_letter_i = f;
    second_letter_i = s;
    key_digit_i = d;
    entry_number_i = num;
    entry_payload_i = pay;
    if (srch == REQ_INSERT) keys_used = {keys_used, {f, s, d}};
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // Drain all results, then write table_size for the next phase.
  task automatic set_size(input logic [SizeW-1:0] sz);
    push = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_wdata_i = sz;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly well-formed keys, reusing inserted ones so that lookups hit.
  task automatic random_word();
    logic [13:0] k;
    logic [4:0]  f, s;
    logic [3:0]  d;
    if (keys_used.size() > 0 && $urandom_range(99) < 55) begin
      k = keys_used[$urandom_range(keys_used.size() - 1)];
      {f, s, d} = k;
    end else if ($urandom_range(99) < 10) begin
      f = 5'($urandom_range(31));
      s = 5'($urandom_range(31));
      d = 4'($urandom_range(15));
    end else begin
      f = 5'($urandom_range(25));
      s = 5'($urandom_range(25));
      d = 4'($urandom_range(9));
    end
    send_word($urandom_range(1) ? REQ_SEARCH : REQ_INSERT, f, s, d, $urandom,
              {$urandom, $urandom});
  endtask

  initial begin
    logic [SizeW-1:0] sizes[6];
    steady = 1'b0;
    idle_cycles = 0;
    sizes = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd17, 7'd5};
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, duplicates, aliased codes, one shared chain.
    send_word(REQ_INSERT, 5'd0, 5'd0, 4'd0, 32'h8000_0000, '1);
    send_word(REQ_INSERT, 5'd25, 5'd25, 4'd9, 32'h7fff_ffff, '0);
    send_word(REQ_INSERT, 5'd0, 5'd0, 4'd0, 32'h1, 64'h1);       // duplicate
    send_word(REQ_SEARCH, 5'd0, 5'd0, 4'd0, '0, '0);
    send_word(REQ_SEARCH, 5'd25, 5'd25, 4'd9, '1, '1);
    send_word(REQ_SEARCH, 5'd1, 5'd1, 4'd5, '0, '0);             // absent
    send_word(REQ_INSERT, 5'd31, 5'd31, 4'd15, 32'hffff_ffff, 64'haaaa_5555_aaaa_5555);
    send_word(REQ_SEARCH, 5'd31, 5'd31, 4'd15, '0, '0);
    // Letter out of range lands on the same code as the next first letter.
    send_word(REQ_INSERT, 5'd1, 5'd0, 4'd0, 32'd260, 64'h5555_aaaa_5555_aaaa);
    send_word(REQ_SEARCH, 5'd0, 5'd26, 4'd0, '0, '0);
    send_word(REQ_INSERT, 5'd0, 5'd0, 4'd10, '0, '0);
    send_word(REQ_INSERT, 5'd0, 5'd1, 4'd0, '0, '0);             // same code
    // Codes 31 and 62 share bucket 0 with AA0 under the reset size.
    send_word(REQ_INSERT, 5'd0, 5'd3, 4'd1, 32'd31, 64'd31);
    send_word(REQ_INSERT, 5'd0, 5'd6, 4'd2, 32'd62, 64'd62);
    send_word(REQ_SEARCH, 5'd0, 5'd3, 4'd1, '0, '0);
    send_word(REQ_SEARCH, 5'd0, 5'd6, 4'd2, '0, '0);
    send_word(REQ_SEARCH, 5'd0, 5'd0, 4'd0, '0, '0);
    send_word(REQ_SEARCH, 5'd0, 5'd9, 4'd3, '0, '0);             // absent in chain

    // Random phases over several sizes; the table keeps filling until full.
    for (int p = 0; p < 6; p++) begin
      set_size(sizes[p]);
      steady = (p == 2);
      for (int i = 0; i < 200; i++) random_word();
    end
    steady = 1'b0;
    set_size(7'd64);
    // Inserts of fresh keys once the pool is exhausted.
    for (int i = 0; i < 20; i++)
      send_word(REQ_INSERT, 5'($urandom_range(31)), 5'($urandom_range(31)),
                4'($urandom_range(15)), $urandom, {$urandom, $urandom});
    push = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    $display("Covered %0d result words over sizes 1, 5, 17, 31, 64, 0 and 127,", checked);
    $display("with %0d lookups found and %0d inserts refused on a full pool.",
             found_hits, full_hits);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
